// File: hw/rtl/bips_pkg.sv
// ----------------------------------------------------------------------------
// bips_pkg
// Shared types and constants for the battery and idle power supervisor.
// ----------------------------------------------------------------------------
package bips_pkg;

    localparam int MV_W    = 16;
    localparam int RUN_W   = 8;
    localparam int IDLE_W  = 16;
    localparam int CMD_W   = 2;
    localparam int CAUSE_W = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 32;

    localparam logic [MV_W-1:0]   WARN_MV_RST     = MV_W'(3550);
    localparam logic [MV_W-1:0]   SHUT_MV_RST     = MV_W'(3400);
    localparam logic [RUN_W-1:0]  SHUT_COUNT_RST  = RUN_W'(3);
    localparam logic [IDLE_W-1:0] IDLE_TIMEOUT_RST = IDLE_W'(300);

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE          = 2'd0,
        CMD_ACTIVITY        = 2'd1,
        CMD_TICK            = 2'd2,
        CMD_POWEROFF_FAILED = 2'd3
    } cmd_t;

    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_NONE     = 2'd0,
        CAUSE_IDLE     = 2'd1,
        CAUSE_LOW_BATT = 2'd2
    } cause_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WARN_MV      = 2'd0,
        REG_SHUT_MV      = 2'd1,
        REG_SHUT_COUNT   = 2'd2,
        REG_IDLE_TIMEOUT = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [MV_W-1:0]   warning_threshold_mv;
        logic [MV_W-1:0]   shutdown_threshold_mv;
        logic [RUN_W-1:0]  shutdown_sample_count;
        logic [IDLE_W-1:0] idle_timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [RUN_W-1:0] low_sample_run;
        cause_t           shutdown_cause;
        logic             shutdown_pulse;
        logic             warning_pulse;
        logic [MV_W-1:0]  filtered_mv;
    } result_t;

endpackage

// File: hw/rtl/bips_core.sv
// ----------------------------------------------------------------------------
// bips_core
// Supervisor state and per-item update: filter, low-run count, idle count,
// warning and shutdown latch. Produces the result of the accepted item.
// ----------------------------------------------------------------------------
module bips_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  bips_pkg::cmd_t      command,
    input  logic                sample_valid,
    input  logic [15:0]         battery_mv,
    input  logic                external_power,
    input  bips_pkg::cfg_t      cfg,
    output bips_pkg::result_t   result
);
    import bips_pkg::*;

    logic              ext_reg,     ext_next;
    logic [MV_W-1:0]   filter_reg,  filter_next;
    logic [RUN_W-1:0]  run_reg,     run_next;
    logic              warned_reg,  warned_next;
    logic              latched_reg, latched_next;
    logic [IDLE_W-1:0] idle_reg,    idle_next;

    logic [MV_W+1:0]   filter_sum;
    logic              want_low;
    logic              want_idle;
    logic              warn;

    always_comb begin
        ext_next     = ext_reg;
        filter_next  = filter_reg;
        run_next     = run_reg;
        warned_next  = warned_reg;
        latched_next = latched_reg;
        idle_next    = idle_reg;
        want_low     = 1'b0;
        want_idle    = 1'b0;
        warn         = 1'b0;
        filter_sum   = ({2'b00, filter_reg} << 1) + {2'b00, filter_reg}
                     + {2'b00, battery_mv};

        unique case (command)
            CMD_SAMPLE: begin
                ext_next = external_power;
                if (!sample_valid || external_power) begin
                    run_next    = '0;
                    warned_next = 1'b0;
                end else begin
                    if (filter_reg == '0) begin
                        filter_next = battery_mv;
                    end else begin
                        filter_next = filter_sum[MV_W+1:2];
                    end
                    if (filter_next <= cfg.warning_threshold_mv && !warned_reg) begin
                        warned_next = 1'b1;
                        warn        = 1'b1;
                    end
                    if (filter_next <= cfg.shutdown_threshold_mv) begin
                        if (run_reg != '1) begin
                            run_next = run_reg + RUN_W'(1);
                        end
                        want_low = (run_next >= cfg.shutdown_sample_count);
                    end else begin
                        run_next = '0;
                    end
                end
            end
            CMD_ACTIVITY: begin
                idle_next = '0;
            end
            CMD_TICK: begin
                if (idle_reg != '1) begin
                    idle_next = idle_reg + IDLE_W'(1);
                end
                want_idle = !ext_reg && (idle_next >= cfg.idle_timeout_ticks);
            end
            CMD_POWEROFF_FAILED: begin
                latched_next = 1'b0;
            end
            default: begin
            end
        endcase

        result.shutdown_cause = CAUSE_NONE;
        result.shutdown_pulse = 1'b0;
        if ((want_low || want_idle) && !latched_reg) begin
            latched_next          = 1'b1;
            result.shutdown_pulse = 1'b1;
            result.shutdown_cause = want_low ? CAUSE_LOW_BATT : CAUSE_IDLE;
        end
        result.filtered_mv    = filter_next;
        result.warning_pulse  = warn;
        result.low_sample_run = run_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_reg     <= 1'b0;
            filter_reg  <= '0;
            run_reg     <= '0;
            warned_reg  <= 1'b0;
            latched_reg <= 1'b0;
            idle_reg    <= '0;
        end else if (accept) begin
            ext_reg     <= ext_next;
            filter_reg  <= filter_next;
            run_reg     <= run_next;
            warned_reg  <= warned_next;
            latched_reg <= latched_next;
            idle_reg    <= idle_next;
        end
    end

endmodule

// File: hw/rtl/battery_and_idle_power_supervisor.sv
// ----------------------------------------------------------------------------
// battery_and_idle_power_supervisor
// Output: an accepted result is registered in the output register, or in
// the skid entry while m_ is stalled. Throughput: one item per cycle while
// s_tready is high; s_tready drops only when both entries are full.
// Reset: synchronous active-low aresetn restores register defaults, clears
// filter, counters, flags, shutdown latch and both output entries.
// ----------------------------------------------------------------------------
module battery_and_idle_power_supervisor (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [bips_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [bips_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [0] sample_valid, [16:1] battery_mv, [17] external_power, [23:18] zero
    input  logic [bips_pkg::S_DATA_W-1:0]     s_tdata,
    // [1:0] command
    input  logic [bips_pkg::CMD_W-1:0]        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] filtered_mv, [16] warning_pulse, [17] shutdown_pulse,
    // [19:18] shutdown_cause, [27:20] low_sample_run, [31:28] zero
    output logic [bips_pkg::M_DATA_W-1:0]     m_tdata
);
    import bips_pkg::*;

    cfg_t    cfg_reg;
    result_t result;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    accept;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.warning_threshold_mv  <= WARN_MV_RST;
            cfg_reg.shutdown_threshold_mv <= SHUT_MV_RST;
            cfg_reg.shutdown_sample_count <= SHUT_COUNT_RST;
            cfg_reg.idle_timeout_ticks    <= IDLE_TIMEOUT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                REG_WARN_MV:      cfg_reg.warning_threshold_mv  <= cfg_wr_data;
                REG_SHUT_MV:      cfg_reg.shutdown_threshold_mv <= cfg_wr_data;
                REG_SHUT_COUNT:   cfg_reg.shutdown_sample_count <= cfg_wr_data[RUN_W-1:0];
                REG_IDLE_TIMEOUT: cfg_reg.idle_timeout_ticks    <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    bips_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .command        (cmd_t'(s_tuser)),
        .sample_valid   (s_tdata[0]),
        .battery_mv     (s_tdata[16:1]),
        .external_power (s_tdata[17]),
        .cfg            (cfg_reg),
        .result         (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (accept) begin
            if (out_valid_reg && !m_tready) begin
                skid_reg       <= result;
                skid_valid_reg <= 1'b1;
            end else begin
                out_reg       <= result;
                out_valid_reg <= 1'b1;
            end
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_reg        <= skid_reg;
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.low_sample_run, out_reg.shutdown_cause,
                       out_reg.shutdown_pulse, out_reg.warning_pulse,
                       out_reg.filtered_mv};

    a_pulse_cause : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[17] == (m_tdata[19:18] != CAUSE_NONE)))
        else $error("shutdown pulse and cause disagree");

    a_cause_code : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[19:18] != 2'd3))
        else $error("undefined shutdown cause");

    a_skid_order : assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_no_drop : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && out_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("item lost while output stalled");

endmodule

// File: sim/battery_and_idle_power_supervisor_tb.sv
// ----------------------------------------------------------------------------
// battery_and_idle_power_supervisor_tb
// Self-checking bench for the power supervisor. A short table of directed
// items covers the register extremes, every command, filter reseed, the
// shutdown latch and external power. Random phases with new register
// settings follow, including a run that saturates the low-sample counter and
// a long idle run. Every result is checked, against expected values in the
// table or against an in-bench behavioral copy of the supervisor.
// ----------------------------------------------------------------------------
module battery_and_idle_power_supervisor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bips_pkg::*;

    typedef struct {
        bit          is_cfg;
        cfg_idx_t    idx;
        logic [15:0] val;
        cmd_t        cmd;
        bit          valid;
        logic [15:0] mv;
        bit          ext;
        bit          typed;
        result_t     want;
    } row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic [CMD_W-1:0]      s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    // supervisor copy: registers and state
    cfg_t        regs = '{WARN_MV_RST, SHUT_MV_RST, SHUT_COUNT_RST, IDLE_TIMEOUT_RST};
    bit          ext_seen = 1'b0;
    logic [15:0] filt_mv = '0;
    logic [7:0]  low_run = '0;
    bit          warned = 1'b0;
    bit          latched = 1'b0;
    logic [15:0] idle_ticks = '0;

    result_t     pending_results[$];
    row_t        plan[$];
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    bit          gaps_on = 1'b1;

    always #5 aclk = ~aclk;

    battery_and_idle_power_supervisor i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    function automatic cause_t grant_shutdown(cause_t why);
        if (latched) return CAUSE_NONE;
        latched = 1'b1;
        return why;
    endfunction

    function automatic result_t supervise(cmd_t cmd, bit valid, logic [15:0] mv, bit ext);
        result_t     r;
        cause_t      why;
        logic [17:0] acc;
        r   = '0;
        why = CAUSE_NONE;
        case (cmd)
            CMD_SAMPLE: begin
                ext_seen = ext;
                if (!valid || ext) begin
                    low_run = '0;
                    warned  = 1'b0;
                end else begin
                    if (filt_mv == '0) begin
                        filt_mv = mv;
                    end else begin
                        acc     = 18'(filt_mv) * 18'd3 + 18'(mv);
                        filt_mv = acc[17:2];
                    end
                    if (filt_mv <= regs.warning_threshold_mv && !warned) begin
                        warned          = 1'b1;
                        r.warning_pulse = 1'b1;
                    end
                    if (filt_mv <= regs.shutdown_threshold_mv) begin
                        if (low_run != 8'hFF) low_run++;
                        if (low_run >= regs.shutdown_sample_count)
                            why = grant_shutdown(CAUSE_LOW_BATT);
                    end else begin
                        low_run = '0;
                    end
                end
            end
            CMD_ACTIVITY: begin
                idle_ticks = '0;
            end
            CMD_TICK: begin
                if (idle_ticks != 16'hFFFF) idle_ticks++;
                if (!ext_seen && idle_ticks >= regs.idle_timeout_ticks)
                    why = grant_shutdown(CAUSE_IDLE);
            end
            default: begin
                latched = 1'b0;
            end
        endcase
        r.filtered_mv    = filt_mv;
        r.shutdown_pulse = (why != CAUSE_NONE);
        r.shutdown_cause = why;
        r.low_sample_run = low_run;
        return r;
    endfunction

    function automatic logic [15:0] draw_mv();
        int level;
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            3: return 16'($urandom_range(1, 4));
            default: begin
                level = $urandom_range(0, 1) ? int'(regs.warning_threshold_mv)
                                             : int'(regs.shutdown_threshold_mv);
                level = level + int'($urandom_range(0, 800)) - 400;
                if (level < 0) level = 0;
                if (level > 65535) level = 65535;
                return 16'(level);
            end
        endcase
    endfunction

    function automatic row_t cfg_row(cfg_idx_t idx, logic [15:0] val);
        row_t r;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        r.cmd    = CMD_SAMPLE;
        r.valid  = 1'b0;
        r.mv     = '0;
        r.ext    = 1'b0;
        r.typed  = 1'b0;
        r.want   = '0;
        return r;
    endfunction

    function automatic row_t op_row(cmd_t cmd, bit valid, logic [15:0] mv, bit ext,
                                    bit typed = 1'b0, result_t want = '0);
        row_t r;
        r.is_cfg = 1'b0;
        r.idx    = REG_WARN_MV;
        r.val    = '0;
        r.cmd    = cmd;
        r.valid  = valid;
        r.mv     = mv;
        r.ext    = ext;
        r.typed  = typed;
        r.want   = want;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatches < 40)
            $display("MISMATCH @%0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic send(cmd_t cmd, bit valid, logic [15:0] mv, bit ext,
                        bit typed = 1'b0, result_t want = '0);
        int unsigned gap;
        result_t     r;
        gap = gaps_on ? $urandom_range(0, 9) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'b0, ext, mv, valid};
        do @(posedge aclk); while (s_tready !== 1'b1);
        r = supervise(cmd, valid, mv, ext);
        pending_results.push_back(typed ? want : r);
        @(negedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_WARN_MV:    regs.warning_threshold_mv  = val;
            REG_SHUT_MV:    regs.shutdown_threshold_mv = val;
            REG_SHUT_COUNT: regs.shutdown_sample_count = val[7:0];
            default:        regs.idle_timeout_ticks    = val;
        endcase
        @(negedge aclk);
    endtask

    // result side
    initial begin
        int unsigned stall;
        result_t     got;
        result_t     want;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = gaps_on ? $urandom_range(0, 9) : 0;
            if (results_seen == 100 || results_seen == 900) stall = 64;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            got = result_t'(m_tdata[27:0]);
            if (pending_results.size() == 0) begin
                report_mismatch("result with none pending", m_tdata, '0);
            end else begin
                want = pending_results.pop_front();
                if (got.filtered_mv !== want.filtered_mv)
                    report_mismatch("filtered_mv", got.filtered_mv, want.filtered_mv);
                if (got.warning_pulse !== want.warning_pulse)
                    report_mismatch("warning_pulse", got.warning_pulse, want.warning_pulse);
                if (got.shutdown_pulse !== want.shutdown_pulse)
                    report_mismatch("shutdown_pulse", got.shutdown_pulse, want.shutdown_pulse);
                if (got.shutdown_cause !== want.shutdown_cause)
                    report_mismatch("shutdown_cause", got.shutdown_cause, want.shutdown_cause);
                if (got.low_sample_run !== want.low_sample_run)
                    report_mismatch("low_sample_run", got.low_sample_run, want.low_sample_run);
            end
            results_seen++;
            @(negedge aclk);
        end
    end

    // stimulus
    initial begin
        int unsigned pick;
        cmd_t        cmd;
        logic [15:0] v [4];

        // expected: run, cause, shutdown, warning, filtered
        plan.push_back(op_row(CMD_TICK,   1'b0, 16'h0000, 1'b0, 1'b1,
                              '{8'd0, CAUSE_NONE, 1'b0, 1'b0, 16'h0000}));
        plan.push_back(op_row(CMD_SAMPLE, 1'b1, 16'h0001, 1'b0, 1'b1,
                              '{8'd1, CAUSE_NONE, 1'b0, 1'b1, 16'h0001}));
        plan.push_back(op_row(CMD_SAMPLE, 1'b1, 16'h0000, 1'b0, 1'b1,
                              '{8'd2, CAUSE_NONE, 1'b0, 1'b0, 16'h0000}));
        plan.push_back(op_row(CMD_SAMPLE, 1'b1, 16'hFFFF, 1'b0, 1'b1,
                              '{8'd0, CAUSE_NONE, 1'b0, 1'b0, 16'hFFFF}));
        plan.push_back(op_row(CMD_SAMPLE, 1'b1, 16'h0000, 1'b0));
        plan.push_back(op_row(CMD_SAMPLE, 1'b0, 16'h1234, 1'b0));
        plan.push_back(op_row(CMD_SAMPLE, 1'b1, 16'h0000, 1'b1));
        plan.push_back(op_row(CMD_ACTIVITY, 1'b1, 16'hFFFF, 1'b1));
        plan.push_back(op_row(CMD_POWEROFF_FAILED, 1'b0, 16'h0000, 1'b0));
        // every low sample requests a shutdown
        plan.push_back(cfg_row(REG_WARN_MV, 16'hFFFF));
        plan.push_back(cfg_row(REG_SHUT_MV, 16'hFFFF));
        plan.push_back(cfg_row(REG_SHUT_COUNT, 16'h0000));
        plan.push_back(op_row(CMD_SAMPLE, 1'b1, 16'd100, 1'b0));
        plan.push_back(op_row(CMD_SAMPLE, 1'b1, 16'd100, 1'b0));
        plan.push_back(op_row(CMD_POWEROFF_FAILED, 1'b0, 16'h0000, 1'b0));
        plan.push_back(op_row(CMD_SAMPLE, 1'b1, 16'h0000, 1'b0));
        // every tick on battery requests a shutdown
        plan.push_back(cfg_row(REG_WARN_MV, 16'h0000));
        plan.push_back(cfg_row(REG_SHUT_MV, 16'h0000));
        plan.push_back(cfg_row(REG_SHUT_COUNT, 16'h00FF));
        plan.push_back(cfg_row(REG_IDLE_TIMEOUT, 16'h0000));
        plan.push_back(op_row(CMD_POWEROFF_FAILED, 1'b0, 16'h0000, 1'b0));
        plan.push_back(op_row(CMD_TICK, 1'b0, 16'h0000, 1'b0));
        plan.push_back(op_row(CMD_TICK, 1'b0, 16'h0000, 1'b0));
        plan.push_back(op_row(CMD_ACTIVITY, 1'b0, 16'h0000, 1'b0));
        plan.push_back(op_row(CMD_POWEROFF_FAILED, 1'b0, 16'h0000, 1'b0));
        plan.push_back(op_row(CMD_SAMPLE, 1'b1, 16'hFFFF, 1'b1));
        plan.push_back(op_row(CMD_TICK, 1'b0, 16'h0000, 1'b0));
        plan.push_back(op_row(CMD_SAMPLE, 1'b0, 16'h0000, 1'b0));
        plan.push_back(op_row(CMD_TICK, 1'b0, 16'h0000, 1'b0));

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                settle();
                write_reg(plan[i].idx, plan[i].val);
            end else begin
                send(plan[i].cmd, plan[i].valid, plan[i].mv, plan[i].ext,
                     plan[i].typed, plan[i].want);
            end
        end

        for (int p = 0; p < 12; p++) begin
            settle();
            gaps_on = (p % 4 != 3);
            case (p)
                0: v = '{16'hFFFF, 16'hFFFF, 16'h00FF, 16'hFFFF};
                1: v = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
                2: v = '{16'($urandom), 16'hFFFF, 16'h00FF, 16'hFFFF};
                3: v = '{16'($urandom), 16'($urandom), 16'($urandom), 16'd100};
                default: begin
                    if ($urandom_range(0, 2) == 0) begin
                        foreach (v[k]) v[k] = 16'($urandom);
                    end else begin
                        v[0] = 16'($urandom_range(2000, 4200));
                        v[1] = 16'($urandom_range(1500, int'(v[0])));
                        v[2] = 16'($urandom_range(0, 6));
                        v[3] = 16'($urandom_range(0, 40));
                    end
                end
            endcase
            for (int k = 0; k < 4; k++) write_reg(cfg_idx_t'(k), v[k]);

            case (p)
                2: begin
                    // every filtered value is low: run count climbs to its ceiling
                    repeat (300) send(CMD_SAMPLE, 1'b1, 16'($urandom), 1'b0);
                end
                3: begin
                    // long idle run past the timeout, no gaps
                    send(CMD_ACTIVITY, 1'b0, 16'h0000, 1'b0);
                    send(CMD_POWEROFF_FAILED, 1'b0, 16'h0000, 1'b0);
                    send(CMD_SAMPLE, 1'b0, 16'($urandom), 1'b0);
                    repeat (120) send(CMD_TICK, 1'b0, 16'h0000, 1'b0);
                    send(CMD_POWEROFF_FAILED, 1'b0, 16'h0000, 1'b0);
                    repeat (2) send(CMD_TICK, 1'b0, 16'h0000, 1'b0);
                end
                default: begin
                    repeat (80) begin
                        pick = $urandom_range(0, 99);
                        cmd  = (pick < 45) ? CMD_SAMPLE :
                               (pick < 75) ? CMD_TICK :
                               (pick < 87) ? CMD_ACTIVITY : CMD_POWEROFF_FAILED;
                        send(cmd, $urandom_range(0, 9) != 0, draw_mv(),
                             $urandom_range(0, 9) == 0);
                    end
                end
            endcase
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (5) @(negedge aclk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: battery_and_idle_power_supervisor.f
hw/rtl/bips_pkg.sv
hw/rtl/bips_core.sv
hw/rtl/battery_and_idle_power_supervisor.sv
sim/battery_and_idle_power_supervisor_tb.sv
